FILE: rtl/delta_list_timer_queue_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delta list timer queue.
// Each macro expects signals clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_TIMER_QUEUE_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

`define DLTQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define DLTQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DLTQ_ASSERT_IMP(lbl, ante, cons, msg)

`define DLTQ_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg
// Types, codes and helper functions of the delta list timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dltq_pkg;

	localparam int MAX_RESULTS = 16;
	localparam int N_W         = 5;
	localparam int SUM_W       = 40;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_SET    = 3'd1;
	localparam logic [2:0] OP_UNSET  = 3'd2;
	localparam logic [2:0] OP_QUERY  = 3'd3;
	localparam logic [2:0] OP_EXPIRE = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_REJECTED = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_NOTDUE   = 3'd4;

	typedef struct packed {
		logic [31:0]        key;
		logic signed [31:0] delta;
	} entry_t;

	typedef logic signed [SUM_W-1:0] sum_t;

	function automatic logic signed [31:0] sat32(input sum_t v);
		logic signed [31:0] r;
		if (v > sum_t'(32'sh7fffffff))
			r = 32'sh7fffffff;
		else if (v < -sum_t'(33'sh080000000))
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic sum_t ext32(input logic signed [31:0] v);
		return {{(SUM_W-32){v[31]}}, v};
	endfunction

endpackage

`default_nettype wire

FILE: rtl/dltq_ram.sv
// ----------------------------------------------------------------------------
// dltq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module dltq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/delta_list_timer_queue.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Sorted timer queue kept as a delta list in one entry RAM.
// ----------------------------------------------------------------------------
// Usage: drive opcode, delay and key_tag and raise start while busy is low;
// that edge accepts the command beat. busy stays high until the final result
// has been issued. Each result beat shows on status, expired_key, remaining,
// wake_request and last for one cycle with done high; the receiver cannot
// stall, so every result is taken in that cycle. last marks the final result
// of a command. Expire gives one beat per popped entry (up to 16), or one
// beat when none is due; every other command gives one beat.
// The entry RAM has one read port with registered read data, so each entry
// visited costs a read. Tick reads the head and writes it back; set, unset
// and query walk the list one entry at a time, and a shift of the list costs
// a read and a write per entry moved. Expire moves every later entry down
// one place, with a read and a write each, per popped entry. Commands rejected
// up front, or issued on an empty queue, are answered from the idle state.
// Reset clears the entry count and the wake flag; RAM contents are left as
// they are, since only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "delta_list_timer_queue_defines.svh"

module delta_list_timer_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         opcode,
	input  wire logic [30:0]        delay,
	input  wire logic [31:0]        key_tag,
	output logic                    done,
	output logic [2:0]              status,
	output logic [31:0]             expired_key,
	output logic signed [31:0]      remaining,
	output logic                    wake_request,
	output logic                    last
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = $bits(dltq_pkg::entry_t);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_TICK = 4'd1;
	localparam logic [3:0] S_SCAN = 4'd2;
	localparam logic [3:0] S_NDC  = 4'd3;
	localparam logic [3:0] S_SHR  = 4'd4;
	localparam logic [3:0] S_SHW  = 4'd5;
	localparam logic [3:0] S_INS  = 4'd6;
	localparam logic [3:0] S_RMR  = 4'd7;
	localparam logic [3:0] S_RMW  = 4'd8;
	localparam logic [3:0] S_EXR  = 4'd9;
	localparam logic [3:0] S_EXP  = 4'd10;

	// Control state.
	logic [3:0]                 state_q, state_n;
	logic [CW-1:0]              count_q, count_n;
	logic                       wake_q, wake_n;
	logic                       done_q, done_n;

	// Working registers.
	logic [2:0]                 op_q, op_n;
	logic [30:0]                delay_q, delay_n;
	logic [31:0]                key_q, key_n;
	logic [CW-1:0]              idx_q, idx_n;
	logic [CW-1:0]              src_q, src_n;
	logic [CW-1:0]              ins_q, ins_n;
	dltq_pkg::sum_t             total_q, total_n;
	logic signed [31:0]         nd_q, nd_n;
	logic signed [31:0]         carry_q, carry_n;
	logic signed [31:0]         merged_q, merged_n;
	logic                       first_q, first_n;
	logic [dltq_pkg::N_W-1:0]   npop_q, npop_n;
	logic [31:0]                popkey_q, popkey_n;

	// Result registers.
	logic [2:0]                 status_q, status_n;
	logic [31:0]                xkey_q, xkey_n;
	logic signed [31:0]         rem_q, rem_n;
	logic                       wreq_q, wreq_n;
	logic                       last_q, last_n;

	// RAM port.
	logic [AW-1:0]              rd_addr;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	dltq_pkg::entry_t           wr_ent;
	logic [EW-1:0]              rd_raw;
	dltq_pkg::entry_t           rd_ent;

	dltq_ram #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_ent),
		.raddr(rd_addr),
		.rdata(rd_raw)
	);

	assign rd_ent = dltq_pkg::entry_t'(rd_raw);

	// Datapath terms shared by the states.
	dltq_pkg::sum_t     d_ext;
	dltq_pkg::sum_t     sum;
	dltq_pkg::sum_t     dly_ext;
	logic [CW-1:0]      idx_inc;
	logic [CW-1:0]      src_inc;
	logic signed [31:0] rm_delta;
	logic               exp_more;

	assign d_ext    = dltq_pkg::ext32(rd_ent.delta);
	assign sum      = total_q + d_ext;
	assign dly_ext  = dltq_pkg::sum_t'({1'b0, delay_q});
	assign idx_inc  = idx_q + 1'b1;
	assign src_inc  = src_q + 1'b1;
	assign rm_delta = first_q ? dltq_pkg::sat32(d_ext + dltq_pkg::ext32(carry_q))
		: rd_ent.delta;
	// After a pop, another beat follows if the new head is due and the
	// per-command limit is not reached.
	assign exp_more = ((npop_q + 1'b1) < dltq_pkg::N_W'(dltq_pkg::MAX_RESULTS)) &&
		((first_q ? rm_delta : merged_q) <= 0);

	always_comb begin
		unique case (state_q)
			S_SCAN:  rd_addr = idx_inc[AW-1:0];
			S_SHR:   rd_addr = src_q[AW-1:0];
			S_RMR:   rd_addr = src_q[AW-1:0];
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		state_n  = state_q;
		count_n  = count_q;
		wake_n   = wake_q;
		done_n   = 1'b0;
		op_n     = op_q;
		delay_n  = delay_q;
		key_n    = key_q;
		idx_n    = idx_q;
		src_n    = src_q;
		ins_n    = ins_q;
		total_n  = total_q;
		nd_n     = nd_q;
		carry_n  = carry_q;
		merged_n = merged_q;
		first_n  = first_q;
		npop_n   = npop_q;
		popkey_n = popkey_q;
		status_n = dltq_pkg::ST_OK;
		xkey_n   = '0;
		rem_n    = '0;
		wreq_n   = 1'b0;
		last_n   = 1'b1;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_ent   = '{key: key_q, delta: nd_q};

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_n    = opcode;
					delay_n = delay;
					key_n   = key_tag;
					idx_n   = '0;
					total_n = '0;
					unique case (opcode)
						dltq_pkg::OP_TICK: begin
							if (count_q == '0)
								done_n = 1'b1;
							else
								state_n = S_TICK;
						end
						dltq_pkg::OP_SET: begin
							if (delay == '0 || key_tag == '0) begin
								done_n   = 1'b1;
								status_n = dltq_pkg::ST_REJECTED;
							end else if (count_q >= FULL_CNT) begin
								done_n   = 1'b1;
								status_n = dltq_pkg::ST_FULL;
							end else if (count_q == '0) begin
								wr_en   = 1'b1;
								wr_ent  = '{key: key_tag, delta: {1'b0, delay}};
								count_n = CW'(1);
								done_n  = 1'b1;
							end else begin
								state_n = S_SCAN;
							end
						end
						dltq_pkg::OP_UNSET, dltq_pkg::OP_QUERY: begin
							if (count_q == '0) begin
								done_n   = 1'b1;
								status_n = dltq_pkg::ST_NOTFOUND;
							end else begin
								state_n = S_SCAN;
							end
						end
						dltq_pkg::OP_EXPIRE: begin
							wake_n = 1'b0;
							npop_n = '0;
							if (count_q == '0) begin
								done_n   = 1'b1;
								status_n = dltq_pkg::ST_NOTDUE;
							end else begin
								state_n = S_EXP;
							end
						end
						default: begin
							done_n   = 1'b1;
							status_n = dltq_pkg::ST_REJECTED;
						end
					endcase
				end
			end

			S_TICK: begin
				wr_en   = 1'b1;
				wr_ent  = '{key: rd_ent.key,
					delta: dltq_pkg::sat32(d_ext - dltq_pkg::sum_t'(1))};
				done_n  = 1'b1;
				state_n = S_IDLE;
				if (wr_ent.delta <= 0 && !wake_q) begin
					wake_n = 1'b1;
					wreq_n = 1'b1;
				end
			end

			S_SCAN: begin
				priority case (op_q)
					dltq_pkg::OP_SET: begin
						if (sum > dly_ext) begin
							ins_n   = idx_q;
							state_n = S_NDC;
						end else begin
							total_n = sum;
							idx_n   = idx_inc;
							if (idx_inc == count_q) begin
								ins_n   = count_q;
								state_n = S_NDC;
							end
						end
					end
					dltq_pkg::OP_UNSET: begin
						if (rd_ent.key == key_q) begin
							if (idx_inc == count_q) begin
								count_n = count_q - 1'b1;
								done_n  = 1'b1;
								state_n = S_IDLE;
							end else begin
								carry_n = rd_ent.delta;
								src_n   = idx_inc;
								first_n = 1'b1;
								state_n = S_RMR;
							end
						end else if (idx_inc == count_q) begin
							done_n   = 1'b1;
							status_n = dltq_pkg::ST_NOTFOUND;
							state_n  = S_IDLE;
						end else begin
							idx_n = idx_inc;
						end
					end
					default: begin
						total_n = sum;
						idx_n   = idx_inc;
						if (rd_ent.key == key_q || idx_inc == count_q) begin
							done_n   = 1'b1;
							rem_n    = dltq_pkg::sat32(sum);
							status_n = (rd_ent.key == key_q) ? dltq_pkg::ST_OK
								: dltq_pkg::ST_NOTFOUND;
							state_n  = S_IDLE;
						end
					end
				endcase
			end

			S_NDC: begin
				nd_n = dltq_pkg::sat32(dly_ext - total_q);
				if (ins_q == count_q) begin
					state_n = S_INS;
				end else begin
					src_n   = count_q - 1'b1;
					state_n = S_SHR;
				end
			end

			S_SHR: begin
				state_n = S_SHW;
			end

			S_SHW: begin
				// The old entry at the insert point moves up and gives up
				// the new timer's delta.
				wr_en   = 1'b1;
				wr_addr = src_inc[AW-1:0];
				wr_ent  = '{key: rd_ent.key,
					delta: (src_q == ins_q) ?
						dltq_pkg::sat32(d_ext - dltq_pkg::ext32(nd_q)) : rd_ent.delta};
				if (src_q == ins_q) begin
					state_n = S_INS;
				end else begin
					src_n   = src_q - 1'b1;
					state_n = S_SHR;
				end
			end

			S_INS: begin
				wr_en   = 1'b1;
				wr_addr = ins_q[AW-1:0];
				count_n = count_q + 1'b1;
				done_n  = 1'b1;
				state_n = S_IDLE;
			end

			S_RMR: begin
				state_n = S_RMW;
			end

			S_RMW: begin
				wr_en   = 1'b1;
				wr_addr = AW'(src_q - 1'b1);
				wr_ent  = '{key: rd_ent.key, delta: rm_delta};
				first_n = 1'b0;
				if (first_q)
					merged_n = rm_delta;
				if (src_inc == count_q) begin
					count_n = count_q - 1'b1;
					done_n  = 1'b1;
					state_n = S_IDLE;
					if (op_q == dltq_pkg::OP_EXPIRE) begin
						xkey_n = popkey_q;
						if (exp_more) begin
							last_n  = 1'b0;
							npop_n  = npop_q + 1'b1;
							state_n = S_EXR;
						end
					end
				end else begin
					src_n   = src_inc;
					state_n = S_RMR;
				end
			end

			S_EXR: begin
				state_n = S_EXP;
			end

			S_EXP: begin
				if (rd_ent.delta <= 0) begin
					popkey_n = rd_ent.key;
					if (count_q == CW'(1)) begin
						count_n = '0;
						done_n  = 1'b1;
						xkey_n  = rd_ent.key;
						state_n = S_IDLE;
					end else begin
						carry_n = rd_ent.delta;
						src_n   = CW'(1);
						first_n = 1'b1;
						state_n = S_RMR;
					end
				end else begin
					done_n   = 1'b1;
					status_n = dltq_pkg::ST_NOTDUE;
					state_n  = S_IDLE;
				end
			end

			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			wake_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			wake_q  <= wake_n;
			done_q  <= done_n;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_n;
		delay_q  <= delay_n;
		key_q    <= key_n;
		idx_q    <= idx_n;
		src_q    <= src_n;
		ins_q    <= ins_n;
		total_q  <= total_n;
		nd_q     <= nd_n;
		carry_q  <= carry_n;
		merged_q <= merged_n;
		first_q  <= first_n;
		npop_q   <= npop_n;
		popkey_q <= popkey_n;
		status_q <= status_n;
		xkey_q   <= xkey_n;
		rem_q    <= rem_n;
		wreq_q   <= wreq_n;
		last_q   <= last_n;
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign expired_key  = xkey_q;
	assign remaining    = rem_q;
	assign wake_request = wreq_q;
	assign last         = last_q;

	`DLTQ_ASSERT_IMP(a_count_range, 1'b1, count_q <= FULL_CNT, "entry count beyond depth")
	`DLTQ_ASSERT_IMP(a_last_idle, done_q && last_q, state_q == S_IDLE, "final beat while busy")
	`DLTQ_ASSERT_IMP(a_more_busy, done_q && !last_q, state_q != S_IDLE, "non-final beat at idle")
	`DLTQ_ASSERT_NXT(a_accept, start && !busy, busy || done_q, "command beat dropped")
	`DLTQ_ASSERT_IMP(a_wake_flag, done_q && wreq_q, wake_q, "wake request without flag")

endmodule

`default_nettype wire

FILE: verif/delta_list_timer_queue_tb.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue_tb
// Self-checking bench for the delta list timer queue. A directed table covers
// empty-queue answers, rejects, unused opcodes, equal delays and wake/expire;
// random command streams with bursts that fill the queue follow. Every result
// beat is compared with a software model of the sorted delta list.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_list_timer_queue_tb;

	localparam int         DEPTH         = 16;
	localparam int         RANDOM_ITEMS  = 430;
	localparam int         STALL_LIMIT   = 5000;
	localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
	localparam logic [2:0] OP_UNUSED_MID = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

	typedef struct {
		logic [2:0]  status;
		logic [31:0] key;
		logic [31:0] rem;
		logic        wake;
		logic        last;
	} beat_t;

	typedef struct {
		logic [2:0]  op;
		logic [30:0] dly;
		logic [31:0] key;
		bit          typed;
		logic [2:0]  st;
	} cmd_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  opcode;
	logic [30:0] delay;
	logic [31:0] key_tag;
	logic        done;
	logic [2:0]  status;
	logic [31:0] expired_key;
	logic signed [31:0] remaining;
	logic        wake_request;
	logic        last;

	delta_list_timer_queue DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .delay(delay), .key_tag(key_tag), .done(done),
		.status(status), .expired_key(expired_key), .remaining(remaining),
		.wake_request(wake_request), .last(last)
	);

	always #10 clk = ~clk;

	// Model of the timer list.
	longint tl_delta [DEPTH];
	logic [31:0] tl_key [DEPTH];
	int     tl_count;
	bit     tl_wake;

	beat_t  pending_beats [$];
	int     errors;
	int     stall_cycles;
	int     idle_pct;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic void drop_entry(input int i);
		if (i + 1 < tl_count)
			tl_delta[i+1] = clamp32(tl_delta[i+1] + tl_delta[i]);
		for (int j = i; j + 1 < tl_count; j++) begin
			tl_delta[j] = tl_delta[j+1];
			tl_key[j] = tl_key[j+1];
		end
		tl_count--;
	endfunction

	function automatic logic [2:0] insert_timer(input longint d, input logic [31:0] k);
		longint total;
		longint nd;
		int i;
		if (d <= 0 || k == 32'd0) return dltq_pkg::ST_REJECTED;
		if (tl_count >= DEPTH) return dltq_pkg::ST_FULL;
		if (tl_count == 0) begin
			tl_delta[0] = d;
			tl_key[0] = k;
			tl_count = 1;
			return dltq_pkg::ST_OK;
		end
		total = tl_delta[0];
		if (total > d) begin
			i = 0;
			nd = d;
		end else begin
			for (i = 1; i < tl_count; i++) begin
				if (total + tl_delta[i] > d) break;
				total += tl_delta[i];
			end
			nd = clamp32(d - total);
		end
		for (int j = tl_count; j > i; j--) begin
			tl_delta[j] = tl_delta[j-1];
			tl_key[j] = tl_key[j-1];
		end
		tl_delta[i] = nd;
		tl_key[i] = k;
		tl_count++;
		if (i + 1 < tl_count)
			tl_delta[i+1] = clamp32(tl_delta[i+1] - nd);
		return dltq_pkg::ST_OK;
	endfunction

	function automatic beat_t mk_beat(input logic [2:0] st, input logic [31:0] k,
			input longint r, input logic w, input logic l);
		beat_t b;
		b.status = st;
		b.key = k;
		b.rem = r[31:0];
		b.wake = w;
		b.last = l;
		return b;
	endfunction

	// Pushes the expected result beats of one accepted command.
	function automatic void predict_timer_beats(input logic [2:0] op, input logic [30:0] d,
			input logic [31:0] k, input bit typed, input logic [2:0] st);
		beat_t  b [$];
		longint total;
		int     i;
		logic   w;
		w = 1'b0;
		case (op)
			dltq_pkg::OP_TICK: begin
				if (tl_count > 0) begin
					tl_delta[0] = clamp32(tl_delta[0] - 1);
					if (tl_delta[0] <= 0 && !tl_wake) begin
						tl_wake = 1'b1;
						w = 1'b1;
					end
				end
				b.push_back(mk_beat(dltq_pkg::ST_OK, 0, 0, w, 1'b1));
			end
			dltq_pkg::OP_SET:
				b.push_back(mk_beat(insert_timer(longint'(d), k), 0, 0, 1'b0, 1'b1));
			dltq_pkg::OP_UNSET: begin
				for (i = 0; i < tl_count; i++)
					if (tl_key[i] == k) break;
				if (i >= tl_count) begin
					b.push_back(mk_beat(dltq_pkg::ST_NOTFOUND, 0, 0, 1'b0, 1'b1));
				end else begin
					drop_entry(i);
					b.push_back(mk_beat(dltq_pkg::ST_OK, 0, 0, 1'b0, 1'b1));
				end
			end
			dltq_pkg::OP_QUERY: begin
				total = 0;
				for (i = 0; i < tl_count; i++) begin
					total += tl_delta[i];
					if (tl_key[i] == k) break;
				end
				b.push_back(mk_beat(i < tl_count ? dltq_pkg::ST_OK : dltq_pkg::ST_NOTFOUND,
					0, clamp32(total), 1'b0, 1'b1));
			end
			dltq_pkg::OP_EXPIRE: begin
				tl_wake = 1'b0;
				while (b.size() < dltq_pkg::MAX_RESULTS && tl_count > 0 &&
						tl_delta[0] <= 0) begin
					b.push_back(mk_beat(dltq_pkg::ST_OK, tl_key[0], 0, 1'b0, 1'b0));
					drop_entry(0);
				end
				if (b.size() == 0)
					b.push_back(mk_beat(dltq_pkg::ST_NOTDUE, 0, 0, 1'b0, 1'b1));
				else
					b[b.size()-1].last = 1'b1;
			end
			default: b.push_back(mk_beat(dltq_pkg::ST_REJECTED, 0, 0, 1'b0, 1'b1));
		endcase
		if (typed)
			b[0].status = st;
		foreach (b[n])
			pending_beats.push_back(b[n]);
	endfunction

	task automatic issue_cmd(input logic [2:0] op, input logic [30:0] d,
			input logic [31:0] k, input bit typed = 0,
			input logic [2:0] st = dltq_pkg::ST_OK);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		opcode <= op;
		delay <= d;
		key_tag <= k;
		start <= 1'b1;
		do @(posedge clk); while (!(start && !busy));
		predict_timer_beats(op, d, k, typed, st);
	endtask

	function automatic logic [31:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 85) return 32'($urandom_range(1, 12));
		if (r < 95) return $urandom();
		return 32'd0;
	endfunction

	function automatic logic [30:0] pick_delay();
		int r;
		r = $urandom_range(99);
		if (r < 80) return 31'($urandom_range(1, 40));
		if (r < 90) return 31'($urandom() >> 1);
		return 31'd0;
	endfunction

	cmd_row_t dir_rows [24] = '{
		'{dltq_pkg::OP_TICK,   31'd0,        32'd0,        1, dltq_pkg::ST_OK},
		'{dltq_pkg::OP_EXPIRE, 31'd0,        32'd0,        1, dltq_pkg::ST_NOTDUE},
		'{dltq_pkg::OP_QUERY,  31'd0,        32'd5,        1, dltq_pkg::ST_NOTFOUND},
		'{dltq_pkg::OP_UNSET,  31'd0,        32'd5,        1, dltq_pkg::ST_NOTFOUND},
		'{dltq_pkg::OP_SET,    31'd0,        32'd5,        1, dltq_pkg::ST_REJECTED},
		'{dltq_pkg::OP_SET,    31'd7,        32'd0,        1, dltq_pkg::ST_REJECTED},
		'{dltq_pkg::OP_SET,    31'd0,        32'd0,        1, dltq_pkg::ST_REJECTED},
		'{OP_UNUSED_LO,        31'h7fffffff, 32'hffffffff, 1, dltq_pkg::ST_REJECTED},
		'{OP_UNUSED_MID,       31'd3,        32'd1,        1, dltq_pkg::ST_REJECTED},
		'{OP_UNUSED_HI,        31'd0,        32'd0,        1, dltq_pkg::ST_REJECTED},
		'{dltq_pkg::OP_SET,    31'h7fffffff, 32'hffffffff, 1, dltq_pkg::ST_OK},
		'{dltq_pkg::OP_SET,    31'd3,        32'd1,        1, dltq_pkg::ST_OK},
		'{dltq_pkg::OP_SET,    31'd3,        32'd2,        1, dltq_pkg::ST_OK},
		'{dltq_pkg::OP_SET,    31'd1,        32'd3,        1, dltq_pkg::ST_OK},
		'{dltq_pkg::OP_QUERY,  31'd0,        32'd2,        0, dltq_pkg::ST_OK},
		'{dltq_pkg::OP_QUERY,  31'd0,        32'hffffffff, 0, dltq_pkg::ST_OK},
		'{dltq_pkg::OP_QUERY,  31'd0,        32'h80000000, 0, dltq_pkg::ST_OK},
		'{dltq_pkg::OP_UNSET,  31'd0,        32'd1,        1, dltq_pkg::ST_OK},
		'{dltq_pkg::OP_TICK,   31'd0,        32'd0,        0, dltq_pkg::ST_OK},
		'{dltq_pkg::OP_TICK,   31'd0,        32'd0,        0, dltq_pkg::ST_OK},
		'{dltq_pkg::OP_TICK,   31'd0,        32'd0,        0, dltq_pkg::ST_OK},
		'{dltq_pkg::OP_TICK,   31'd0,        32'd0,        0, dltq_pkg::ST_OK},
		'{dltq_pkg::OP_EXPIRE, 31'd0,        32'd0,        0, dltq_pkg::ST_OK},
		'{dltq_pkg::OP_EXPIRE, 31'd0,        32'd0,        0, dltq_pkg::ST_OK}
	};

	// Result beats cannot be held off, so each one is checked in its cycle.
	always @(posedge clk) begin
		beat_t e;
		if (arst_n && done) begin
			if (pending_beats.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = pending_beats.pop_front();
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status);
					errors++;
				end
				if (expired_key !== e.key) begin
					$error("expired_key: expected %h, got %h", e.key, expired_key);
					errors++;
				end
				if (remaining !== e.rem) begin
					$error("remaining: expected %h, got %h", e.rem, remaining);
					errors++;
				end
				if (wake_request !== e.wake) begin
					$error("wake_request: expected %b, got %b", e.wake, wake_request);
					errors++;
				end
				if (last !== e.last) begin
					$error("last: expected %b, got %b", e.last, last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int n;
		int r;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = dltq_pkg::OP_TICK;
		delay = '0;
		key_tag = '0;
		errors = 0;
		stall_cycles = 0;
		idle_pct = 37;
		tl_count = 0;
		tl_wake = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			issue_cmd(dir_rows[i].op, dir_rows[i].dly, dir_rows[i].key,
				dir_rows[i].typed, dir_rows[i].st);

		n = 0;
		while (n < RANDOM_ITEMS) begin
			idle_pct = (n < RANDOM_ITEMS / 3) ? 37 : (n < 2 * RANDOM_ITEMS / 3) ? 45 : 0;
			r = $urandom_range(99);
			if (r < 35) begin
				issue_cmd(dltq_pkg::OP_SET, pick_delay(), pick_key());
				n++;
			end else if (r < 60) begin
				issue_cmd(dltq_pkg::OP_TICK, 31'($urandom() >> 1), $urandom());
				n++;
			end else if (r < 70) begin
				issue_cmd(dltq_pkg::OP_EXPIRE, 31'($urandom() >> 1), $urandom());
				n++;
			end else if (r < 80) begin
				issue_cmd(dltq_pkg::OP_UNSET, 31'($urandom() >> 1), pick_key());
				n++;
			end else if (r < 92) begin
				issue_cmd(dltq_pkg::OP_QUERY, 31'($urandom() >> 1), pick_key());
				n++;
			end else if (r < 96) begin
				// A burst that overruns the queue, all with short delays so
				// that several entries fall due together.
				repeat (DEPTH + 1) begin
					issue_cmd(dltq_pkg::OP_SET, 31'($urandom_range(1, 4)),
						$urandom() | 32'd1);
					n++;
				end
			end else begin
				issue_cmd(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
					31'($urandom() >> 1), $urandom());
				n++;
			end
		end
		start <= 1'b0;

		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
